// File: rtl/core/rtbbe_pkg.sv
// ----------------------------------------------------------------------------
// Residency table package
// Shared constants, opcodes, status codes and controller/datapath types.
// ----------------------------------------------------------------------------
package rtbbe_pkg;

    localparam int REF_COUNT_DEF  = 32;
    localparam int BYTE_BITS_DEF  = 40;
    localparam int COUNT_BITS_DEF = 16;

    localparam int ORD_BITS   = 32;
    localparam int EVC_BITS   = 32;
    localparam int SCORE_BITS = 32;
    // Quotient bits per score term; both terms stay below 2^20.
    localparam int DIV_QBITS  = 20;
    localparam int DIV_CBITS  = $clog2(DIV_QBITS);

    localparam logic [2:0] OP_REQUEST = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_ACQUIRE = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_EVICT   = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_ABSENT  = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_TOO_BIG = 3'd3;
    localparam logic [2:0] ST_NO_ROOM = 3'd4;
    localparam logic [2:0] ST_LEASED  = 3'd5;

    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_POLICY = 1'b1;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLRWR,
        ACT_LOAD,
        ACT_RD_REF,
        ACT_EXEC,
        ACT_INSERT,
        ACT_NOROOM,
        ACT_SCAN_INIT,
        ACT_RD_IDX,
        ACT_P1,
        ACT_P2,
        ACT_DIV_STEP,
        ACT_MID,
        ACT_ADDQ,
        ACT_CMP,
        ACT_DROP
    } t_act;

    typedef enum logic [1:0] {
        NX_DONE,
        NX_FIT,
        NX_SWEEP
    } t_next;

    typedef struct packed {
        t_act act;
        logic sweep;
        logic result;
        logic idx_clr;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        t_next nx;
        logic  fits;
        logic  cand;
        logic  any;
        logic  mc_nz;
        logic  policy;
        logic  idx_last;
        logic  div_last;
    } t_sts;

endpackage

// File: rtl/core/rtbbe_item_if.sv
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel carrying one table operation.
// ----------------------------------------------------------------------------
interface rtbbe_item_if #(
    parameter int REF_W  = 5,
    parameter int BYTE_W = 40
);
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic [REF_W-1:0]  slot_ref;
    logic [BYTE_W-1:0] size_bytes;

    modport source (output valid, opcode, slot_ref, size_bytes, input ready);
    modport sink   (input valid, opcode, slot_ref, size_bytes, output ready);
endinterface

// File: rtl/core/rtbbe_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one operation result and table totals.
// ----------------------------------------------------------------------------
interface rtbbe_res_if #(
    parameter int REF_W   = 5,
    parameter int ENT_W   = 6,
    parameter int BYTE_W  = 40,
    parameter int LEASE_W = 21
);
    logic               valid;
    logic               ready;
    logic               ok;
    logic [2:0]         status;
    logic [ENT_W-1:0]   evictions;
    logic [REF_W-1:0]   last_victim;
    logic [BYTE_W-1:0]  resident_total;
    logic [ENT_W-1:0]   resident_entries;
    logic [LEASE_W-1:0] lease_sum;
    logic [31:0]        eviction_total;

    modport source (output valid, ok, status, evictions, last_victim, resident_total,
                    resident_entries, lease_sum, eviction_total, input ready);
    modport sink   (input valid, ok, status, evictions, last_victim, resident_total,
                    resident_entries, lease_sum, eviction_total, output ready);
endinterface

// File: rtl/core/rtbbe_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel with register index and data.
// ----------------------------------------------------------------------------
interface rtbbe_cfg_if #(
    parameter int BYTE_W = 40
);
    logic              valid;
    logic              ready;
    logic              index;
    logic [BYTE_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rtbbe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtbbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/rtbbe_ctrl.sv
// ----------------------------------------------------------------------------
// Residency table controller
// Sequences the clearing pass, single-slot operations, victim search and sweep.
// ----------------------------------------------------------------------------
module rtbbe_ctrl
    import rtbbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [17:0] {
        S_CLR   = 18'h00001,
        S_IDLE  = 18'h00002,
        S_RD    = 18'h00004,
        S_EXEC  = 18'h00008,
        S_FIT   = 18'h00010,
        S_P1RD  = 18'h00020,
        S_P1    = 18'h00040,
        S_P2RD  = 18'h00080,
        S_P2    = 18'h00100,
        S_DIV1  = 18'h00200,
        S_MID   = 18'h00400,
        S_DIV2  = 18'h00800,
        S_ADD2  = 18'h01000,
        S_CMP   = 18'h02000,
        S_DROP  = 18'h04000,
        S_SWRD  = 18'h08000,
        S_SW    = 18'h10000,
        S_DONE  = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '{act: ACT_NONE, sweep: 1'b0, result: 1'b0,
                        idx_clr: 1'b0, idx_inc: 1'b0};
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLR: begin
                o_cmd.act = ACT_CLRWR;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.act = ACT_LOAD;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                o_cmd.act = ACT_RD_REF;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.act = ACT_EXEC;
                case (i_sts.nx)
                    NX_FIT:   n_state = S_FIT;
                    NX_SWEEP: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_SWRD;
                    end
                    default:  n_state = S_DONE;
                endcase
            end
            S_FIT: begin
                if (i_sts.fits) begin
                    o_cmd.act = ACT_INSERT;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.act     = ACT_SCAN_INIT;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_P1RD;
                end
            end
            S_P1RD: begin
                o_cmd.act = ACT_RD_IDX;
                n_state   = S_P1;
            end
            S_P1: begin
                o_cmd.act = ACT_P1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_P2RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_P1RD;
                end
            end
            S_P2RD: begin
                // With no candidate at all, the insert gives up.
                if (!i_sts.any) begin
                    o_cmd.act = ACT_NOROOM;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.act = ACT_RD_IDX;
                    n_state   = S_P2;
                end
            end
            S_P2: begin
                if (i_sts.cand) begin
                    o_cmd.act = ACT_P2;
                    if (!i_sts.policy) begin
                        n_state = S_CMP;
                    end else if (i_sts.mc_nz) begin
                        n_state = S_DIV1;
                    end else begin
                        n_state = S_DIV2;
                    end
                end else if (i_sts.idx_last) begin
                    n_state = S_DROP;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_P2RD;
                end
            end
            S_DIV1: begin
                o_cmd.act = ACT_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_MID;
                end
            end
            S_MID: begin
                o_cmd.act = ACT_MID;
                n_state   = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.act = ACT_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_ADD2;
                end
            end
            S_ADD2: begin
                o_cmd.act = ACT_ADDQ;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.act = ACT_CMP;
                if (i_sts.idx_last) begin
                    n_state = S_DROP;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_P2RD;
                end
            end
            S_DROP: begin
                o_cmd.act = ACT_DROP;
                n_state   = S_FIT;
            end
            S_SWRD: begin
                o_cmd.act = ACT_RD_IDX;
                n_state   = S_SW;
            end
            S_SW: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SWRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.result = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// File: rtl/core/rtbbe_dp.sv
// ----------------------------------------------------------------------------
// Residency table datapath
// Slot memory, table totals, scan registers, score divider and result register.
// ----------------------------------------------------------------------------
module rtbbe_dp
    import rtbbe_pkg::*;
#(
    parameter int REF_COUNT  = REF_COUNT_DEF,
    parameter int BYTE_BITS  = BYTE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_cmd                                     i_cmd,
    output t_sts                                     o_sts,
    input  logic                                     i_cfg_we,
    input  logic                                     i_cfg_index,
    input  logic [BYTE_BITS-1:0]                     i_cfg_data,
    input  logic [2:0]                               i_opcode,
    input  logic [$clog2(REF_COUNT)-1:0]             i_slot_ref,
    input  logic [BYTE_BITS-1:0]                     i_size_bytes,
    output logic                                     o_ok,
    output logic [2:0]                               o_status,
    output logic [$clog2(REF_COUNT+1)-1:0]           o_evictions,
    output logic [$clog2(REF_COUNT)-1:0]             o_last_victim,
    output logic [BYTE_BITS-1:0]                     o_resident_total,
    output logic [$clog2(REF_COUNT+1)-1:0]           o_resident_entries,
    output logic [$clog2(REF_COUNT)+COUNT_BITS-1:0]  o_lease_sum,
    output logic [EVC_BITS-1:0]                      o_eviction_total
);
    localparam int IDX_W   = $clog2(REF_COUNT);
    localparam int ENT_W   = $clog2(REF_COUNT+1);
    localparam int LEASE_W = IDX_W + COUNT_BITS;
    localparam int E_W     = 1 + 2*COUNT_BITS + ORD_BITS + BYTE_BITS;
    localparam int DIV_W   = ORD_BITS + 1;
    localparam int DVD_W   = (COUNT_BITS + 20 > DIV_W + 16) ? COUNT_BITS + 20 : DIV_W + 16;
    localparam int NINE_W  = COUNT_BITS + 4;

    // Entry layout: {valid, leases, requests, stamp, bytes}.
    localparam int B_LO = 0;
    localparam int S_LO = BYTE_BITS;
    localparam int Q_LO = S_LO + ORD_BITS;
    localparam int L_LO = Q_LO + COUNT_BITS;

    logic [2:0]             r_op;
    logic [IDX_W-1:0]       r_ref;
    logic [BYTE_BITS-1:0]   r_size;
    logic [COUNT_BITS-1:0]  r_keep_req;
    logic [ORD_BITS-1:0]    r_keep_stamp;
    logic [BYTE_BITS-1:0]   r_budget;
    logic                   r_policy;
    logic [BYTE_BITS-1:0]   r_used;
    logic [ENT_W-1:0]       r_entries;
    logic [LEASE_W-1:0]     r_lease_tot;
    logic [EVC_BITS-1:0]    r_evc;
    logic [ORD_BITS-1:0]    r_ord;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_ok;
    logic [2:0]             r_status;
    logic [ENT_W-1:0]       r_evs;
    logic [IDX_W-1:0]       r_last;
    logic                   r_any;
    logic [COUNT_BITS-1:0]  r_maxcnt;
    logic [ORD_BITS-1:0]    r_minage;
    logic                   r_found;
    logic [IDX_W-1:0]       r_best_idx;
    logic [SCORE_BITS-1:0]  r_best_score;
    logic [E_W-1:0]         r_best_ent;
    logic [E_W-1:0]         r_cand_ent;
    logic [ORD_BITS-1:0]    r_cand_age;
    logic [SCORE_BITS-1:0]  r_score;
    logic [DIV_W-1:0]       r_rem;
    logic [DIV_W-1:0]       r_dvs;
    logic [DIV_QBITS-1:0]   r_q;
    logic [DIV_CBITS-1:0]   r_dcnt;

    logic                   r_o_ok;
    logic [2:0]             r_o_status;
    logic [ENT_W-1:0]       r_o_evs;
    logic [IDX_W-1:0]       r_o_last;
    logic [BYTE_BITS-1:0]   r_o_total;
    logic [ENT_W-1:0]       r_o_entries;
    logic [LEASE_W-1:0]     r_o_lease;
    logic [EVC_BITS-1:0]    r_o_evc;

    logic                   we, re;
    logic [IDX_W-1:0]       waddr, raddr;
    logic [E_W-1:0]         wdata, rdata;

    logic                   rd_valid;
    logic [COUNT_BITS-1:0]  rd_leases, rd_req, rd_den;
    logic [ORD_BITS-1:0]    rd_stamp, rd_age;
    logic [BYTE_BITS-1:0]   rd_bytes;
    logic                   cand, in_range, lease_full;
    logic [NINE_W-1:0]      nine_d;
    logic [DVD_W-1:0]       dvd1, dvd2_rd, dvd2_cand;
    logic [DIV_W-1:0]       t_step;
    logic [DIV_W:0]         t_wide;
    logic                   ge;
    logic [BYTE_BITS:0]     fit_sum;

    rtbbe_ram #(.WIDTH(E_W), .DEPTH(REF_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_valid  = rdata[E_W-1];
    assign rd_leases = rdata[L_LO +: COUNT_BITS];
    assign rd_req    = rdata[Q_LO +: COUNT_BITS];
    assign rd_stamp  = rdata[S_LO +: ORD_BITS];
    assign rd_bytes  = rdata[B_LO +: BYTE_BITS];
    assign rd_den    = (rd_bytes == '0) ? '0 : rd_req;
    assign rd_age    = (r_ord >= rd_stamp) ? r_ord - rd_stamp : '0;
    assign cand      = rd_valid && (rd_leases == '0);
    assign in_range  = ({1'b0, r_ref} < (IDX_W+1)'(REF_COUNT));
    assign lease_full = (rd_leases == '1);

    assign nine_d    = NINE_W'({rd_den, 3'b000}) + NINE_W'(rd_den);
    assign dvd1      = DVD_W'({nine_d, 16'h0000});
    assign dvd2_rd   = DVD_W'({(DIV_W'(r_minage) + DIV_W'(1)), 16'h0000});
    assign dvd2_cand = dvd2_rd;
    assign fit_sum   = {1'b0, r_used} + {1'b0, r_size};

    // One restoring division step; the remainder always stays below the divisor.
    assign t_wide = {r_rem, r_q[DIV_QBITS-1]};
    assign ge     = (t_wide >= {1'b0, r_dvs});
    assign t_step = ge ? DIV_W'(t_wide - {1'b0, r_dvs}) : DIV_W'(t_wide);

    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = r_idx;
        raddr = r_idx;
        wdata = '0;
        case (i_cmd.act)
            ACT_CLRWR: we = 1'b1;
            ACT_RD_REF: begin
                re    = 1'b1;
                raddr = r_ref;
            end
            ACT_RD_IDX: re = 1'b1;
            ACT_EXEC: begin
                waddr = r_ref;
                wdata = rdata;
                if (in_range) begin
                    case (r_op)
                        OP_REQUEST: begin
                            we = 1'b1;
                            wdata[Q_LO +: COUNT_BITS] = (rd_req == '1) ? rd_req
                                                                       : rd_req + 1'b1;
                            wdata[S_LO +: ORD_BITS]   = (r_ord == '1) ? r_ord
                                                                      : r_ord + 1'b1;
                        end
                        OP_ACQUIRE: begin
                            we = rd_valid && !lease_full;
                            wdata[L_LO +: COUNT_BITS] = rd_leases + 1'b1;
                        end
                        OP_RELEASE: begin
                            we = rd_valid && (rd_leases != '0);
                            wdata[L_LO +: COUNT_BITS] = rd_leases - 1'b1;
                        end
                        OP_EVICT: begin
                            we = cand;
                            wdata[E_W-1] = 1'b0;
                        end
                        default: we = 1'b0;
                    endcase
                end
            end
            ACT_INSERT: begin
                we    = 1'b1;
                waddr = r_ref;
                wdata = {1'b1, {COUNT_BITS{1'b0}}, r_keep_req, r_keep_stamp, r_size};
            end
            ACT_DROP: begin
                we    = 1'b1;
                waddr = r_best_idx;
                wdata = {1'b0, r_best_ent[E_W-2:0]};
            end
            default: we = 1'b0;
        endcase
        if (i_cmd.sweep && cand) begin
            we    = 1'b1;
            waddr = r_idx;
            wdata = {1'b0, rdata[E_W-2:0]};
        end
    end

    always_comb begin
        o_sts.nx = NX_DONE;
        if (in_range && (r_op == OP_INSERT) && !rd_valid && (r_size <= r_budget)) begin
            o_sts.nx = NX_FIT;
        end else if (in_range && (r_op == OP_CLEAR)) begin
            o_sts.nx = NX_SWEEP;
        end
        o_sts.fits     = (fit_sum <= {1'b0, r_budget});
        o_sts.cand     = cand;
        o_sts.any      = r_any;
        o_sts.mc_nz    = (r_maxcnt != '0);
        o_sts.policy   = r_policy;
        o_sts.idx_last = (r_idx == IDX_W'(REF_COUNT - 1));
        o_sts.div_last = (r_dcnt == DIV_CBITS'(DIV_QBITS - 1));
    end

    // Control state and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= '0;
            r_policy    <= 1'b0;
            r_used      <= '0;
            r_entries   <= '0;
            r_lease_tot <= '0;
            r_evc       <= '0;
            r_ord       <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BUDGET) begin
                    r_budget <= i_cfg_data;
                end else begin
                    r_policy <= i_cfg_data[0];
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.act == ACT_EXEC && in_range) begin
                case (r_op)
                    OP_REQUEST: begin
                        if (r_ord != '1) begin
                            r_ord <= r_ord + 1'b1;
                        end
                    end
                    OP_ACQUIRE: begin
                        if (rd_valid && !lease_full) begin
                            r_lease_tot <= r_lease_tot + 1'b1;
                        end
                    end
                    OP_RELEASE: begin
                        if (rd_valid && rd_leases != '0) begin
                            r_lease_tot <= r_lease_tot - 1'b1;
                        end
                    end
                    OP_EVICT: begin
                        if (cand) begin
                            r_used    <= r_used - rd_bytes;
                            r_entries <= r_entries - 1'b1;
                            if (r_evc != '1) begin
                                r_evc <= r_evc + 1'b1;
                            end
                        end
                    end
                    default: r_used <= r_used;
                endcase
            end
            if (i_cmd.act == ACT_INSERT) begin
                r_used    <= r_used + r_size;
                r_entries <= r_entries + 1'b1;
            end
            if (i_cmd.act == ACT_DROP) begin
                r_used    <= r_used - r_best_ent[B_LO +: BYTE_BITS];
                r_entries <= r_entries - 1'b1;
                if (r_evc != '1) begin
                    r_evc <= r_evc + 1'b1;
                end
            end
            if (i_cmd.sweep && cand) begin
                r_used    <= r_used - rd_bytes;
                r_entries <= r_entries - 1'b1;
            end
        end
    end

    // Item, scan, divider and result payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            ACT_LOAD: begin
                r_op     <= i_opcode;
                r_ref    <= i_slot_ref;
                r_size   <= i_size_bytes;
                r_ok     <= 1'b1;
                r_status <= ST_DONE;
                r_evs    <= '0;
                r_last   <= '0;
            end
            ACT_EXEC: begin
                r_keep_req   <= rd_req;
                r_keep_stamp <= rd_stamp;
                if (!in_range) begin
                    if (r_op <= OP_CLEAR) begin
                        r_ok     <= 1'b0;
                        r_status <= ST_ABSENT;
                    end
                end else begin
                    case (r_op)
                        OP_INSERT: begin
                            if (rd_valid) begin
                                r_ok     <= 1'b0;
                                r_status <= ST_PRESENT;
                            end else if (r_size > r_budget) begin
                                r_ok     <= 1'b0;
                                r_status <= ST_TOO_BIG;
                            end
                        end
                        OP_ACQUIRE: begin
                            if (!rd_valid) begin
                                r_ok     <= 1'b0;
                                r_status <= ST_ABSENT;
                            end
                        end
                        OP_RELEASE: begin
                            if (!rd_valid || rd_leases == '0) begin
                                r_ok     <= 1'b0;
                                r_status <= ST_ABSENT;
                            end
                        end
                        OP_EVICT: begin
                            if (!rd_valid) begin
                                r_ok     <= 1'b0;
                                r_status <= ST_ABSENT;
                            end else if (rd_leases != '0) begin
                                r_ok     <= 1'b0;
                                r_status <= ST_LEASED;
                            end else begin
                                r_evs  <= ENT_W'(1);
                                r_last <= r_ref;
                            end
                        end
                        default: r_ok <= r_ok;
                    endcase
                end
            end
            ACT_NOROOM: begin
                r_ok     <= 1'b0;
                r_status <= ST_NO_ROOM;
            end
            ACT_SCAN_INIT: begin
                r_any   <= 1'b0;
                r_found <= 1'b0;
            end
            ACT_P1: begin
                if (cand) begin
                    if (!r_any || rd_den > r_maxcnt) begin
                        r_maxcnt <= rd_den;
                    end
                    if (!r_any || rd_age < r_minage) begin
                        r_minage <= rd_age;
                    end
                    r_any <= 1'b1;
                end
            end
            ACT_P2: begin
                r_cand_ent <= rdata;
                r_cand_age <= rd_age;
                r_dcnt     <= '0;
                if (!r_policy) begin
                    r_score <= rd_stamp;
                end else begin
                    r_score <= '0;
                    if (r_maxcnt != '0) begin
                        r_rem <= DIV_W'(dvd1 >> DIV_QBITS);
                        r_q   <= dvd1[DIV_QBITS-1:0];
                        r_dvs <= DIV_W'(r_maxcnt);
                    end else begin
                        r_rem <= DIV_W'(dvd2_rd >> DIV_QBITS);
                        r_q   <= dvd2_rd[DIV_QBITS-1:0];
                        r_dvs <= DIV_W'(rd_age) + DIV_W'(1);
                    end
                end
            end
            ACT_DIV_STEP: begin
                r_rem  <= t_step;
                r_q    <= {r_q[DIV_QBITS-2:0], ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            ACT_MID: begin
                r_score <= r_score + SCORE_BITS'(r_q);
                r_rem   <= DIV_W'(dvd2_cand >> DIV_QBITS);
                r_q     <= dvd2_cand[DIV_QBITS-1:0];
                r_dvs   <= DIV_W'(r_cand_age) + DIV_W'(1);
                r_dcnt  <= '0;
            end
            ACT_ADDQ: r_score <= r_score + SCORE_BITS'(r_q);
            ACT_CMP: begin
                if (!r_found || r_score < r_best_score) begin
                    r_found      <= 1'b1;
                    r_best_idx   <= r_idx;
                    r_best_score <= r_score;
                    r_best_ent   <= r_cand_ent;
                end
            end
            ACT_DROP: begin
                r_evs  <= r_evs + 1'b1;
                r_last <= r_best_idx;
            end
            default: r_any <= r_any;
        endcase
        if (i_cmd.result) begin
            r_o_ok      <= r_ok;
            r_o_status  <= r_status;
            r_o_evs     <= r_evs;
            r_o_last    <= r_last;
            r_o_total   <= r_used;
            r_o_entries <= r_entries;
            r_o_lease   <= r_lease_tot;
            r_o_evc     <= r_evc;
        end
    end

    assign o_ok               = r_o_ok;
    assign o_status           = r_o_status;
    assign o_evictions        = r_o_evs;
    assign o_last_victim      = r_o_last;
    assign o_resident_total   = r_o_total;
    assign o_resident_entries = r_o_entries;
    assign o_lease_sum        = r_o_lease;
    assign o_eviction_total   = r_o_evc;
endmodule

// File: rtl/core/residency_table_byte_budget_evict_unit.sv
// ----------------------------------------------------------------------------
// Residency table with byte budget and victim eviction
// Slot table under a byte budget with LRU or cost-aware victim choice.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Each victim of an insert costs a candidate pass and a score
// pass over every slot; in the score pass each candidate is scored by its stamp (LRU) or by
// two bit-serial divisions on the shared divider (cost-aware; only the second division when
// all counts are zero).
// After reset a clearing pass over every slot runs before items are taken.
module residency_table_byte_budget_evict_unit
    import rtbbe_pkg::*;
#(
    parameter int REF_COUNT  = REF_COUNT_DEF,
    parameter int BYTE_BITS  = BYTE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rtbbe_cfg_if.sink    i_cfg,
    rtbbe_item_if.sink   i_item,
    rtbbe_res_if.source  o_res
);
    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    rtbbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rtbbe_dp #(
        .REF_COUNT  (REF_COUNT),
        .BYTE_BITS  (BYTE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .i_opcode           (i_item.opcode),
        .i_slot_ref         (i_item.slot_ref),
        .i_size_bytes       (i_item.size_bytes),
        .o_ok               (o_res.ok),
        .o_status           (o_res.status),
        .o_evictions        (o_res.evictions),
        .o_last_victim      (o_res.last_victim),
        .o_resident_total   (o_res.resident_total),
        .o_resident_entries (o_res.resident_entries),
        .o_lease_sum        (o_res.lease_sum),
        .o_eviction_total   (o_res.eviction_total)
    );

    // The controller leaves idle right after taking an item.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("item taken while another is in flight");

    a_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.resident_entries <= REF_COUNT))
        else $error("resident entry count above table size");

    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ok |-> (o_res.status == ST_DONE))
        else $error("successful result with failure status");
endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Residency table testbench
// Drives table operations and configuration writes into the residency table,
// predicts every result with a local copy of the slot table and compares each
// result transfer field by field. A directed table comes first, then random
// traffic under several budgets and both victim policies, with random idling
// on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import rtbbe_pkg::*;

    localparam int          NREF       = 32;
    localparam logic [39:0] BYTE_MAX   = 40'hFF_FFFF_FFFF;
    localparam int          PHASE_ITEMS = 270;
    localparam int          STALL_LIMIT = 400000;
    localparam logic [2:0]  OP_UNUSED6 = 3'd6;
    localparam logic [2:0]  OP_UNUSED7 = 3'd7;

    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic [5:0]  evictions;
        logic [4:0]  last_victim;
        logic [39:0] resident_total;
        logic [5:0]  resident_entries;
        logic [20:0] lease_sum;
        logic [31:0] eviction_total;
    } t_result;

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  sref;
        logic [39:0] size;
        logic        typed;
        logic        ok;
        logic [2:0]  status;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtbbe_cfg_if  #(.BYTE_W(40)) cfg_ch ();
    rtbbe_item_if #(.REF_W(5), .BYTE_W(40)) item_ch ();
    rtbbe_res_if  #(.REF_W(5), .ENT_W(6), .BYTE_W(40), .LEASE_W(21)) res_ch ();

    residency_table_byte_budget_evict_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_item  (item_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the slot table.
    logic        tbl_valid    [NREF];
    logic [39:0] tbl_bytes    [NREF];
    logic [15:0] tbl_leases   [NREF];
    logic [15:0] tbl_requests [NREF];
    logic [31:0] tbl_stamp    [NREF];
    logic [31:0] ordinal;
    logic [39:0] bytes_used;
    logic [5:0]  entries;
    logic [21:0] leases_held;
    logic [31:0] evicted_count;
    logic [39:0] budget;
    logic        cost_policy;

    t_result expected_results[$];
    int      fail_count = 0;
    int      results_seen = 0;
    int      victim_inserts = 0;
    int      snd_idle = 0;
    int      rcv_idle = 0;
    logic    hold_request = 1'b0;
    logic    hold_done = 1'b0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    function automatic logic [63:0] slot_age(int r);
        return (ordinal >= tbl_stamp[r]) ? 64'(ordinal - tbl_stamp[r]) : 64'd0;
    endfunction

    function automatic logic [63:0] slot_weight(int r);
        return (tbl_bytes[r] == 0) ? 64'd0 : 64'(tbl_requests[r]);
    endfunction

    // Returns NREF when every resident slot is leased.
    function automatic int choose_victim();
        int          best;
        logic [63:0] maxcount, minage, best_score, score;
        logic        any;
        best = NREF;
        maxcount = 0;
        minage = 0;
        best_score = 0;
        any = 1'b0;
        for (int r = 0; r < NREF; r++) begin
            if (tbl_valid[r] && tbl_leases[r] == 0) begin
                if (!any || slot_weight(r) > maxcount) maxcount = slot_weight(r);
                if (!any || slot_age(r) < minage) minage = slot_age(r);
                any = 1'b1;
            end
        end
        for (int r = 0; r < NREF; r++) begin
            if (tbl_valid[r] && tbl_leases[r] == 0) begin
                if (!cost_policy) begin
                    score = 64'(tbl_stamp[r]);
                end else begin
                    score = (maxcount == 0) ? 64'd0
                          : ((64'd9 * slot_weight(r)) << 16) / maxcount;
                    score += ((minage + 64'd1) << 16) / (slot_age(r) + 64'd1);
                end
                if (best == NREF || score < best_score) begin
                    best = r;
                    best_score = score;
                end
            end
        end
        return best;
    endfunction

    function automatic void drop_entry(int r);
        bytes_used -= tbl_bytes[r];
        tbl_valid[r] = 1'b0;
        entries--;
    endfunction

    function automatic void bump_evicted();
        if (evicted_count != 32'hFFFF_FFFF) evicted_count++;
    endfunction

    function automatic t_result apply_table_op(logic [2:0] op, logic [4:0] sref,
                                               logic [39:0] size);
        t_result res;
        int      r, v;
        res = '0;
        res.ok = 1'b1;
        res.status = ST_DONE;
        r = int'(sref);
        case (op)
            OP_REQUEST: begin
                if (ordinal != 32'hFFFF_FFFF) ordinal++;
                if (tbl_requests[r] != 16'hFFFF) tbl_requests[r]++;
                tbl_stamp[r] = ordinal;
            end
            OP_INSERT: begin
                if (tbl_valid[r]) begin
                    res.ok = 1'b0; res.status = ST_PRESENT;
                end else if (size > budget) begin
                    res.ok = 1'b0; res.status = ST_TOO_BIG;
                end else begin
                    while (41'(bytes_used) + 41'(size) > 41'(budget)) begin
                        v = choose_victim();
                        if (v >= NREF) break;
                        drop_entry(v);
                        bump_evicted();
                        res.evictions++;
                        res.last_victim = 5'(v);
                    end
                    if (res.evictions != 0) victim_inserts++;
                    if (41'(bytes_used) + 41'(size) > 41'(budget)) begin
                        res.ok = 1'b0; res.status = ST_NO_ROOM;
                    end else begin
                        tbl_valid[r] = 1'b1;
                        tbl_bytes[r] = size;
                        tbl_leases[r] = 0;
                        bytes_used += size;
                        entries++;
                    end
                end
            end
            OP_ACQUIRE: begin
                if (!tbl_valid[r]) begin
                    res.ok = 1'b0; res.status = ST_ABSENT;
                end else if (tbl_leases[r] != 16'hFFFF) begin
                    tbl_leases[r]++;
                    leases_held++;
                end
            end
            OP_RELEASE: begin
                if (!tbl_valid[r] || tbl_leases[r] == 0) begin
                    res.ok = 1'b0; res.status = ST_ABSENT;
                end else begin
                    tbl_leases[r]--;
                    leases_held--;
                end
            end
            OP_EVICT: begin
                if (!tbl_valid[r]) begin
                    res.ok = 1'b0; res.status = ST_ABSENT;
                end else if (tbl_leases[r] != 0) begin
                    res.ok = 1'b0; res.status = ST_LEASED;
                end else begin
                    drop_entry(r);
                    bump_evicted();
                    res.evictions = 6'd1;
                    res.last_victim = sref;
                end
            end
            OP_CLEAR: begin
                for (int k = 0; k < NREF; k++)
                    if (tbl_valid[k] && tbl_leases[k] == 0) drop_entry(k);
            end
            default: ;
        endcase
        res.resident_total = bytes_used;
        res.resident_entries = entries;
        res.lease_sum = leases_held[20:0];
        res.eviction_total = evicted_count;
        return res;
    endfunction

    // Leaves valid high so that a following write goes out back to back.
    task automatic write_register(logic index, logic [39:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (index == CFG_BUDGET) budget = value;
        else cost_policy = value[0];
    endtask

    // Waits until every outstanding result has come back, then reprograms.
    task automatic reconfigure(logic [39:0] new_budget, logic new_policy);
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        write_register(CFG_BUDGET, new_budget);
        write_register(CFG_POLICY, new_policy);
        cfg_ch.valid <= 1'b0;
    endtask

    // Leaves valid high after the transfer so back-to-back items need no re-raise.
    task automatic offer_item(logic [2:0] op, logic [4:0] sref, logic [39:0] size,
                              output t_result predicted);
        while ($urandom_range(99) < snd_idle) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.opcode     <= op;
        item_ch.slot_ref   <= sref;
        item_ch.size_bytes <= size;
        do @(posedge i_clk); while (!item_ch.ready);
        predicted = apply_table_op(op, sref, size);
        expected_results = {expected_results, predicted};
    endtask

    function automatic logic [39:0] pick_size();
        logic [63:0] raw;
        int          kind;
        raw = {$urandom, $urandom};
        kind = $urandom_range(99);
        if (kind < 70) return 40'(raw % (64'(budget >> 2) + 64'd1));
        if (kind < 78) return 40'd0;
        if (kind < 90) return raw[39:0];
        if (kind < 95) return budget;
        return budget + 40'd1;
    endfunction

    function automatic logic [2:0] pick_opcode();
        int w;
        w = $urandom_range(99);
        if (w < 25) return OP_REQUEST;
        if (w < 57) return OP_INSERT;
        if (w < 72) return OP_ACQUIRE;
        if (w < 85) return OP_RELEASE;
        if (w < 94) return OP_EVICT;
        if (w < 97) return OP_CLEAR;
        return ($urandom_range(1) != 0) ? OP_UNUSED6 : OP_UNUSED7;
    endfunction

    t_row directed_rows [] = '{
        // Reset budget is zero: a zero-byte tensor fits, one byte does not.
        '{OP_INSERT,  5'd2,  40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_INSERT,  5'd3,  40'd1,    1'b1, 1'b0, ST_TOO_BIG},
        '{OP_ACQUIRE, 5'd5,  40'd0,    1'b1, 1'b0, ST_ABSENT},
        '{OP_RELEASE, 5'd5,  40'd0,    1'b1, 1'b0, ST_ABSENT},
        '{OP_EVICT,   5'd5,  40'd0,    1'b1, 1'b0, ST_ABSENT},
        '{OP_INSERT,  5'd5,  BYTE_MAX, 1'b1, 1'b0, ST_TOO_BIG},
        '{OP_INSERT,  5'd5,  40'd1001, 1'b1, 1'b0, ST_TOO_BIG},
        '{OP_INSERT,  5'd5,  40'd400,  1'b1, 1'b1, ST_DONE},
        '{OP_INSERT,  5'd5,  40'd10,   1'b1, 1'b0, ST_PRESENT},
        '{OP_INSERT,  5'd6,  40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_REQUEST, 5'd5,  40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_REQUEST, 5'd9,  40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_ACQUIRE, 5'd5,  40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_EVICT,   5'd5,  40'd0,    1'b1, 1'b0, ST_LEASED},
        '{OP_INSERT,  5'd7,  40'd600,  1'b1, 1'b1, ST_DONE},
        '{OP_INSERT,  5'd8,  40'd300,  1'b0, 1'b0, ST_DONE},
        '{OP_INSERT,  5'd9,  40'd700,  1'b0, 1'b0, ST_DONE},
        '{OP_RELEASE, 5'd5,  40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_RELEASE, 5'd5,  40'd0,    1'b1, 1'b0, ST_ABSENT},
        '{OP_UNUSED6, 5'd0,  40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_UNUSED7, 5'd31, BYTE_MAX, 1'b1, 1'b1, ST_DONE},
        '{OP_CLEAR,   5'd0,  40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_REQUEST, 5'd31, 40'd0,    1'b1, 1'b1, ST_DONE},
        '{OP_INSERT,  5'd31, 40'd1000, 1'b1, 1'b1, ST_DONE},
        '{OP_EVICT,   5'd31, 40'd0,    1'b1, 1'b1, ST_DONE}
    };

    // Result checking, receiver idling, the long hold-off and the watchdog.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (hold_request && !hold_done) begin
                if (hold_left == 0) hold_left <= 600;
                else if (hold_left == 1) hold_done <= 1'b1;
                else hold_left <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= rcv_idle);
            end
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, res_ch.ok);
                        fail_count++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        fail_count++;
                    end
                    if (res_ch.evictions !== want.evictions) begin
                        $error("evictions: expected %0d, got %0d",
                               want.evictions, res_ch.evictions);
                        fail_count++;
                    end
                    if (res_ch.last_victim !== want.last_victim) begin
                        $error("last_victim: expected %0d, got %0d",
                               want.last_victim, res_ch.last_victim);
                        fail_count++;
                    end
                    if (res_ch.resident_total !== want.resident_total) begin
                        $error("resident_total: expected %0d, got %0d",
                               want.resident_total, res_ch.resident_total);
                        fail_count++;
                    end
                    if (res_ch.resident_entries !== want.resident_entries) begin
                        $error("resident_entries: expected %0d, got %0d",
                               want.resident_entries, res_ch.resident_entries);
                        fail_count++;
                    end
                    if (res_ch.lease_sum !== want.lease_sum) begin
                        $error("lease_sum: expected %0d, got %0d",
                               want.lease_sum, res_ch.lease_sum);
                        fail_count++;
                    end
                    if (res_ch.eviction_total !== want.eviction_total) begin
                        $error("eviction_total: expected %0d, got %0d",
                               want.eviction_total, res_ch.eviction_total);
                        fail_count++;
                    end
                end
            end
            if ((res_ch.valid && res_ch.ready) || (item_ch.valid && item_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_result     predicted;
        logic [39:0] phase_budget [4];
        logic        phase_policy [4];
        phase_budget = '{BYTE_MAX, 40'd5000, 40'd5000, 40'd3000};
        phase_policy = '{1'b1, 1'b1, 1'b0, 1'b1};

        for (int r = 0; r < NREF; r++) begin
            tbl_valid[r] = 1'b0;
            tbl_bytes[r] = '0;
            tbl_leases[r] = '0;
            tbl_requests[r] = '0;
            tbl_stamp[r] = '0;
        end
        ordinal = '0;
        bytes_used = '0;
        entries = '0;
        leases_held = '0;
        evicted_count = '0;
        budget = '0;
        cost_policy = 1'b0;

        i_rst_n            <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_BUDGET;
        cfg_ch.data        <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.opcode     <= OP_REQUEST;
        item_ch.slot_ref   <= '0;
        item_ch.size_bytes <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle = 32;
        rcv_idle = 63;
        foreach (directed_rows[i]) begin
            // The budget switch after the two reset-budget inserts.
            if (i == 2) reconfigure(40'd1000, 1'b0);
            offer_item(directed_rows[i].op, directed_rows[i].sref,
                       directed_rows[i].size, predicted);
            if (directed_rows[i].typed && (predicted.ok !== directed_rows[i].ok
                || predicted.status !== directed_rows[i].status)) begin
                $error("status: row %0d expected %0d, predicted %0d",
                       i, directed_rows[i].status, predicted.status);
                fail_count++;
            end
        end

        for (int p = 0; p < 4; p++) begin
            reconfigure(phase_budget[p], phase_policy[p]);
            if (p == 1) begin
                snd_idle = 63;
                rcv_idle = 32;
            end else if (p == 2) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Back up the result side once while the sender keeps offering.
                if (p == 0 && n == 40) hold_request = 1'b1;
                offer_item(pick_opcode(), 5'($urandom_range(NREF - 1)), pick_size(),
                           predicted);
            end
        end
        item_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d results, %0d inserts that evicted, %0d evictions in total,",
                 results_seen, victim_inserts, evicted_count);
        $display("over budgets from zero to full scale under both victim policies.");
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
